// ===== hw/rtl/hud_pkg.sv =====
// hud_pkg: shared types, codes and constants for the hci uart packet deframer
// no dependencies; used by the channel interfaces, hud_step and the top level
package hud_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 2048;

  localparam int unsigned CNT_W   = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned SUM_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // operation codes
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // packet type bytes
  localparam logic [BYTE_W-1:0] TYPE_ACL   = 8'h02;
  localparam logic [BYTE_W-1:0] TYPE_SCO   = 8'h03;
  localparam logic [BYTE_W-1:0] TYPE_EVENT = 8'h04;

  // header lengths after the type byte
  localparam logic [CNT_W-1:0] HDR_EVENT = 11'd2;
  localparam logic [CNT_W-1:0] HDR_ACL   = 11'd4;
  localparam logic [CNT_W-1:0] HDR_SCO   = 11'd3;

  // offset of the low length byte of an acl header
  localparam logic [CNT_W-1:0] ACL_LEN_LO_OFS = 11'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACL_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCO_MAX   = 2'd2;

  localparam logic [CNT_W-1:0] EVENT_MAX_RST = 11'd260;
  localparam logic [CNT_W-1:0] ACL_MAX_RST   = 11'd1028;
  localparam logic [CNT_W-1:0] SCO_MAX_RST   = 11'd255;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_ACL   = 2'd2,
    KIND_SCO   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED   = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_ILLEGAL    = 3'd2,
    ST_UNEXPECTED = 3'd3,
    ST_TOO_LARGE  = 3'd4
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [CNT_W-1:0]   byte_count;
    logic [CNT_W-1:0]   expected_count;
    logic               header_done;
    logic [BYTE_W-1:0]  len_lo;
  } hud_state_t;

  typedef struct packed {
    status_t            status;
    logic               byte_stored;
    logic [BYTE_W-1:0]  byte_out;
    logic [CNT_W-1:0]   byte_offset;
    kind_t              kind;
  } hud_result_t;

  typedef struct packed {
    logic [CNT_W-1:0] event_max;
    logic [CNT_W-1:0] acl_max;
    logic [CNT_W-1:0] sco_max;
  } hud_limits_t;

endpackage

// ===== hw/rtl/hud_in_if.sv =====
// hud_in_if: received byte channel (valid/ready) of the deframer
// depends on hud_pkg for field widths
interface hud_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [hud_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// ===== hw/rtl/hud_out_if.sv =====
// hud_out_if: result channel (valid/ready) of the deframer
// depends on hud_pkg for field widths
interface hud_out_if;
  logic                        valid;
  logic                        ready;
  logic [hud_pkg::STAT_W-1:0]  status;
  logic                        byte_stored;
  logic [hud_pkg::BYTE_W-1:0]  byte_out;
  logic [hud_pkg::CNT_W-1:0]   byte_offset;
  logic [hud_pkg::KIND_W-1:0]  kind;

  modport source (output valid, output status, output byte_stored, output byte_out,
                  output byte_offset, output kind, input ready);
  modport sink   (input valid, input status, input byte_stored, input byte_out,
                  input byte_offset, input kind, output ready);
endinterface

// ===== hw/rtl/hud_cfg_if.sv =====
// hud_cfg_if: configuration write channel (valid/ready) of the deframer
// depends on hud_pkg for index and data widths
interface hud_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hud_pkg::CFG_IDX_W-1:0] index;
  logic [hud_pkg::CNT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/hci_uart_packet_deframer.sv =====
// hci_uart_packet_deframer: h4 uart receive deframer, one result per item
// each accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle unless the result side stalls, set by the single
// decision stage in hud_step; input and result registers are separated, stalls on the
// result side only hold the input side once both are full; rst_n is synchronous, active low,
// and clears parser state, stage valids and the limit registers to their defaults
module hci_uart_packet_deframer #(
  parameter int unsigned MAX_PACKET_BYTES = hud_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hud_in_if.sink     in_ch,
  hud_out_if.source  out_ch,
  hud_cfg_if.sink    cfg_ch
);

  hud_pkg::hud_limits_t        limits_r;
  hud_pkg::hud_state_t         state_r;
  hud_pkg::hud_state_t         state_nxt;
  hud_pkg::hud_result_t        res_nxt;
  hud_pkg::hud_result_t        out_res_r;
  logic                        in_vld_r;
  logic                        in_op_r;
  logic [hud_pkg::BYTE_W-1:0]  in_byte_r;
  logic                        out_vld_r;
  logic                        adv;

  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign cfg_ch.ready = 1'b1;

  hud_step #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_step (
    .st        (state_r),
    .limits    (limits_r),
    .operation (in_op_r),
    .rx_byte   (in_byte_r),
    .st_nxt    (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.event_max     <= hud_pkg::EVENT_MAX_RST;
      limits_r.acl_max       <= hud_pkg::ACL_MAX_RST;
      limits_r.sco_max       <= hud_pkg::SCO_MAX_RST;
      state_r.kind           <= hud_pkg::KIND_NONE;
      state_r.byte_count     <= '0;
      state_r.expected_count <= '0;
      state_r.header_done    <= 1'b0;
      in_vld_r               <= 1'b0;
      out_vld_r              <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          hud_pkg::REG_EVENT_MAX: limits_r.event_max <= cfg_ch.data;
          hud_pkg::REG_ACL_MAX:   limits_r.acl_max   <= cfg_ch.data;
          hud_pkg::REG_SCO_MAX:   limits_r.sco_max   <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (adv) begin
        state_r.kind           <= state_nxt.kind;
        state_r.byte_count     <= state_nxt.byte_count;
        state_r.expected_count <= state_nxt.expected_count;
        state_r.header_done    <= state_nxt.header_done;
        state_r.len_lo         <= state_nxt.len_lo;
        out_vld_r              <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_op_r   <= in_ch.operation;
      in_byte_r <= in_ch.rx_byte;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.byte_stored = out_res_r.byte_stored;
  assign out_ch.byte_out    = out_res_r.byte_out;
  assign out_ch.byte_offset = out_res_r.byte_offset;
  assign out_ch.kind        = out_res_r.kind;

`ifndef SYNTHESIS
  // the parser never counts past the end it expects
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.byte_count <= state_r.expected_count)
    else $error("byte count beyond expected count");

  a_hdr_needs_kind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.header_done |-> (state_r.kind != hud_pkg::KIND_NONE))
    else $error("header done with no packet kind");

  a_stored_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.byte_stored) |->
      (out_res_r.status != hud_pkg::ST_ILLEGAL && out_res_r.status != hud_pkg::ST_UNEXPECTED))
    else $error("stored byte reported as rejected");

  a_illegal_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.status == hud_pkg::ST_ILLEGAL) |->
      (out_res_r.kind == hud_pkg::KIND_NONE))
    else $error("illegal type left a packet kind");

  // an item waiting in the input register is not dropped while the result stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r)
    else $error("pending item lost");
`endif

endmodule

// ===== hw/rtl/hud_step.sv =====
// hud_step: parser decision for one item, next parser state and the result
// depends on hud_pkg; purely combinational, used between the deframer's registers
module hud_step #(
  parameter int unsigned MAX_PACKET_BYTES = hud_pkg::MAX_PACKET_BYTES_DEF
) (
  input  hud_pkg::hud_state_t              st,
  input  hud_pkg::hud_limits_t             limits,
  input  logic                             operation,
  input  logic [hud_pkg::BYTE_W-1:0]       rx_byte,
  output hud_pkg::hud_state_t              st_nxt,
  output hud_pkg::hud_result_t             res
);

  localparam logic [hud_pkg::SUM_W-1:0] CAP = hud_pkg::SUM_W'(MAX_PACKET_BYTES - 1);

  logic [hud_pkg::CNT_W-1:0] cnt_inc;
  logic [hud_pkg::LEN_W-1:0] payload;
  logic [hud_pkg::CNT_W-1:0] reg_max;
  logic [hud_pkg::SUM_W-1:0] reg_max_w;
  logic [hud_pkg::SUM_W-1:0] limit;
  logic [hud_pkg::SUM_W-1:0] total;

  assign cnt_inc = st.byte_count + 11'd1;

  // the last header byte is the current byte, so the length comes from it and, for acl, len_lo
  always_comb begin
    case (st.kind)
      hud_pkg::KIND_ACL: begin
        payload = {rx_byte, st.len_lo};
        reg_max = limits.acl_max;
      end
      hud_pkg::KIND_SCO: begin
        payload = {8'h00, rx_byte};
        reg_max = limits.sco_max;
      end
      default: begin
        payload = {8'h00, rx_byte};
        reg_max = limits.event_max;
      end
    endcase
  end

  assign reg_max_w = {{(hud_pkg::SUM_W - hud_pkg::CNT_W){1'b0}}, reg_max};
  assign limit     = (reg_max_w < CAP) ? reg_max_w : CAP;
  assign total     = {1'b0, payload} + {{(hud_pkg::SUM_W - hud_pkg::CNT_W){1'b0}}, cnt_inc};

  always_comb begin
    st_nxt          = st;
    res.status      = hud_pkg::ST_ACCEPTED;
    res.byte_stored = 1'b0;
    res.byte_out    = rx_byte;
    res.byte_offset = '0;
    if (operation == hud_pkg::OP_RESTART) begin
      st_nxt.kind           = hud_pkg::KIND_NONE;
      st_nxt.byte_count     = '0;
      st_nxt.expected_count = '0;
      st_nxt.header_done    = 1'b0;
      res.byte_out          = '0;
    end else if (st.kind == hud_pkg::KIND_NONE) begin
      case (rx_byte)
        hud_pkg::TYPE_EVENT: begin
          st_nxt.kind           = hud_pkg::KIND_EVENT;
          st_nxt.expected_count = hud_pkg::HDR_EVENT;
        end
        hud_pkg::TYPE_ACL: begin
          st_nxt.kind           = hud_pkg::KIND_ACL;
          st_nxt.expected_count = hud_pkg::HDR_ACL;
        end
        hud_pkg::TYPE_SCO: begin
          st_nxt.kind           = hud_pkg::KIND_SCO;
          st_nxt.expected_count = hud_pkg::HDR_SCO;
        end
        default: res.status = hud_pkg::ST_ILLEGAL;
      endcase
    end else if (st.byte_count >= st.expected_count) begin
      res.status = hud_pkg::ST_UNEXPECTED;
    end else begin
      res.byte_stored   = 1'b1;
      res.byte_offset   = st.byte_count;
      st_nxt.byte_count = cnt_inc;
      if (st.byte_count == hud_pkg::ACL_LEN_LO_OFS) begin
        st_nxt.len_lo = rx_byte;
      end
      if (cnt_inc != st.expected_count) begin
        res.status = hud_pkg::ST_ACCEPTED;
      end else if (st.header_done) begin
        res.status = hud_pkg::ST_COMPLETE;
      end else if (total > limit) begin
        res.status = hud_pkg::ST_TOO_LARGE;
      end else begin
        // total fits in 11 bits here, so the new end cannot wrap
        st_nxt.expected_count = st.expected_count + payload[hud_pkg::CNT_W-1:0];
        st_nxt.header_done    = 1'b1;
        res.status = (payload == '0) ? hud_pkg::ST_COMPLETE : hud_pkg::ST_ACCEPTED;
      end
    end
    res.kind = st_nxt.kind;
  end

endmodule
